>>> src/ffha_pkg.sv
// Shared constants, operation codes and interface types of the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_BYTES  = 65536;
  localparam int HEAP_WORDS  = HEAP_BYTES / 4;
  localparam int AW          = $clog2(HEAP_WORDS);
  localparam int WALK_LIMIT  = HEAP_WORDS + 2;
  localparam int CNT_W       = $clog2(2 * WALK_LIMIT + 1);

  localparam logic [31:0] SIG_FREE = 32'h4642_4C4B;
  localparam logic [31:0] SIG_USED = 32'h5542_4C4B;
  localparam logic [31:0] SIG_END  = 32'h4542_4C4B;
  localparam logic [31:0] NIL      = 32'hFFFF_FFFF;
  localparam logic [31:0] HDR      = 32'd12;
  localparam logic [31:0] MIN_ALLOC = 32'd8;
  localparam logic [31:0] ALIGN_MASK = 32'h3;

  localparam logic [2:0] ACT_ALLOC   = 3'd0;
  localparam logic [2:0] ACT_FREE    = 3'd1;
  localparam logic [2:0] ACT_COMPACT = 3'd2;
  localparam logic [2:0] ACT_WRITE   = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_BADSIG  = 3'd3;
  localparam logic [2:0] ST_BADEND  = 3'd4;
  localparam logic [2:0] ST_CORRUPT = 3'd5;

  localparam logic [5:0] S_CLEAR    = 6'd0;
  localparam logic [5:0] S_IDLE     = 6'd1;
  localparam logic [5:0] S_DECODE   = 6'd2;
  localparam logic [5:0] S_RW_CAP   = 6'd3;
  localparam logic [5:0] S_FIN      = 6'd4;
  localparam logic [5:0] S_FR_SZ    = 6'd5;
  localparam logic [5:0] S_FR_SIG   = 6'd6;
  localparam logic [5:0] S_FR_END   = 6'd7;
  localparam logic [5:0] S_FR_LOOP  = 6'd8;
  localparam logic [5:0] S_CI_0     = 6'd9;
  localparam logic [5:0] S_CI_1     = 6'd10;
  localparam logic [5:0] S_CI_2     = 6'd11;
  localparam logic [5:0] S_MN_0     = 6'd12;
  localparam logic [5:0] S_MN_1     = 6'd13;
  localparam logic [5:0] S_MN_2     = 6'd14;
  localparam logic [5:0] S_MN_3     = 6'd15;
  localparam logic [5:0] S_MN_4     = 6'd16;
  localparam logic [5:0] S_MN_5     = 6'd17;
  localparam logic [5:0] S_MN_6     = 6'd18;
  localparam logic [5:0] S_MN_7     = 6'd19;
  localparam logic [5:0] S_CO_0     = 6'd20;
  localparam logic [5:0] S_CO_1     = 6'd21;
  localparam logic [5:0] S_CO_2     = 6'd22;
  localparam logic [5:0] S_CO_3     = 6'd23;
  localparam logic [5:0] S_FF_START = 6'd24;
  localparam logic [5:0] S_FF_1     = 6'd25;
  localparam logic [5:0] S_FF_2     = 6'd26;
  localparam logic [5:0] S_FF_3     = 6'd27;
  localparam logic [5:0] S_SP_0     = 6'd28;
  localparam logic [5:0] S_SP_1     = 6'd29;
  localparam logic [5:0] S_SP_2     = 6'd30;
  localparam logic [5:0] S_SP_3     = 6'd31;
  localparam logic [5:0] S_SP_5     = 6'd32;
  localparam logic [5:0] S_SP_6     = 6'd33;
  localparam logic [5:0] S_AL_0     = 6'd34;
  localparam logic [5:0] S_AL_1     = 6'd35;
  localparam logic [5:0] S_AL_2     = 6'd36;
  localparam logic [5:0] S_AL_3     = 6'd37;
  localparam logic [5:0] S_AL_NF    = 6'd38;
  localparam logic [5:0] S_CP_START = 6'd39;
  localparam logic [5:0] S_CP_1     = 6'd40;
  localparam logic [5:0] S_CP_M     = 6'd41;
  localparam logic [5:0] S_CP_M2    = 6'd42;
  localparam logic [5:0] S_CP_NX    = 6'd43;
  localparam logic [5:0] S_CP_FAIL  = 6'd44;

  typedef struct packed {
    logic [5:0] op;
    logic       latch;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       rd_free;
    logic       rd_used;
    logic       rd_end;
    logic       rd_nil;
    logic       pv_nil;
    logic       hv;
    logic       fit;
    logic       split_ok;
    logic       cnt_ff_ok;
    logic       cnt_cp_ok;
    logic       mx_ge_s;
    logic       off_bad;
    logic       word_oor;
    logic       sweep_last;
  } flags_t;

endpackage

>>> src/first_fit_heap_allocator.sv
// First-fit heap allocator top level: controller and datapath, one request at a time.
// A write or read touches one heap word and a range error ends the request; free checks
// the block's signature and end marker, links it into the free chain and merges each free
// block that follows it; alloc walks the free chain and, on a miss, compacts the heap and
// retries once if a large enough block formed. done_o lasts one cycle and cannot be stalled;
// the next request may be accepted in it. After reset a clear of every heap word holds busy high.
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] byte_offset_i,
  input  logic [31:0] write_word_i,
  output logic [2:0]  status_o,
  output logic [15:0] payload_offset_o,
  output logic [31:0] read_word_o,
  output logic [16:0] bytes_in_use_o,
  output logic [12:0] used_block_count_o,
  output logic [12:0] free_block_count_o
);

  ffha_pkg::cmd_t   cmd;
  ffha_pkg::flags_t flags;

  ffha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .flags_i (flags),
    .cmd_o   (cmd)
  );

  ffha_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .flags_o            (flags),
    .action_i           (action_i),
    .request_bytes_i    (request_bytes_i),
    .byte_offset_i      (byte_offset_i),
    .write_word_i       (write_word_i),
    .status_o           (status_o),
    .payload_offset_o   (payload_offset_o),
    .read_word_o        (read_word_o),
    .bytes_in_use_o     (bytes_in_use_o),
    .used_block_count_o (used_block_count_o),
    .free_block_count_o (free_block_count_o)
  );

endmodule

>>> src/ffha_dpath.sv
// Datapath of the heap allocator: heap memory, walk registers, counters and result registers.
module ffha_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffha_pkg::cmd_t       cmd_i,
  output ffha_pkg::flags_t     flags_o,
  input  logic [2:0]           action_i,
  input  logic [15:0]          request_bytes_i,
  input  logic [15:0]          byte_offset_i,
  input  logic [31:0]          write_word_i,
  output logic [2:0]           status_o,
  output logic [15:0]          payload_offset_o,
  output logic [31:0]          read_word_o,
  output logic [16:0]          bytes_in_use_o,
  output logic [12:0]          used_block_count_o,
  output logic [12:0]          free_block_count_o
);

  logic [31:0] mem [ffha_pkg::HEAP_WORDS];
  logic [31:0] mem_q;
  logic        inr_q;
  logic [31:0] rd;

  logic [2:0]  act_q;
  logic [15:0] req_q, off_q;
  logic [31:0] wdat_q;
  logic [31:0] s_q, b_q, h_q, n_q, nx_q, pv_q, nt_q, t_q, mx_q, head_q;
  logic        hv_q, corrupt_q, stay_q;
  logic [ffha_pkg::CNT_W-1:0] cnt_q;
  logic [ffha_pkg::AW-1:0]    sweep_q;
  logic [2:0]  status_q;
  logic [15:0] payload_q;
  logic [31:0] rword_q;
  logic [16:0] ubytes_q;
  logic [12:0] ublk_q, fblk_q;

  logic [31:0] addr, wd, off32;
  logic        we, inr;
  logic [31:0] clr_val;
  logic [17:0] s_raw;
  logic [31:0] s_new;

  assign rd    = inr_q ? mem_q : 32'd0;
  assign off32 = {16'd0, off_q};
  assign inr   = addr < 32'(ffha_pkg::HEAP_BYTES);

  always_comb begin
    s_raw = ({2'b00, req_q} + 18'd7) & ~18'd3;
    s_new = {14'd0, s_raw};
    if (s_new < ffha_pkg::MIN_ALLOC) begin
      s_new = ffha_pkg::MIN_ALLOC;
    end
  end

  always_comb begin
    addr = 32'd0;
    we   = 1'b0;
    wd   = 32'd0;
    case (cmd_i.op)
      ffha_pkg::S_DECODE: begin
        if (act_q == ffha_pkg::ACT_FREE) begin
          addr = off32 - 32'd8;
        end else begin
          addr = {14'd0, off_q, 2'b00};
          we   = (act_q == ffha_pkg::ACT_WRITE);
          wd   = wdat_q;
        end
      end
      ffha_pkg::S_FR_SZ:  addr = h_q;
      ffha_pkg::S_FR_SIG: addr = off32 + t_q - 32'd4;
      ffha_pkg::S_FR_END: begin
        addr = h_q;
        we   = (rd == ffha_pkg::SIG_END);
        wd   = ffha_pkg::SIG_FREE;
      end
      ffha_pkg::S_CI_0: begin
        addr = n_q + 32'd12;
        we   = 1'b1;
        wd   = ffha_pkg::NIL;
      end
      ffha_pkg::S_CI_1: begin
        addr = n_q + 32'd16;
        we   = 1'b1;
        wd   = hv_q ? head_q : ffha_pkg::NIL;
      end
      ffha_pkg::S_CI_2: begin
        addr = head_q + 32'd12;
        we   = 1'b1;
        wd   = n_q;
      end
      ffha_pkg::S_MN_0: addr = b_q + 32'd8;
      ffha_pkg::S_MN_1: addr = rd;
      ffha_pkg::S_MN_3: addr = b_q + 32'd4;
      ffha_pkg::S_MN_4: addr = nx_q + 32'd4;
      ffha_pkg::S_MN_5: begin
        addr = b_q + 32'd4;
        we   = 1'b1;
        wd   = t_q + ffha_pkg::HDR + rd;
      end
      ffha_pkg::S_MN_6: addr = nx_q + 32'd8;
      ffha_pkg::S_MN_7: begin
        addr = b_q + 32'd8;
        we   = 1'b1;
        wd   = rd;
      end
      ffha_pkg::S_CO_0: addr = n_q + 32'd12;
      ffha_pkg::S_CO_1: addr = n_q + 32'd16;
      ffha_pkg::S_CO_2: begin
        if (pv_q == ffha_pkg::NIL) begin
          addr = rd + 32'd12;
          we   = (rd != ffha_pkg::NIL);
          wd   = ffha_pkg::NIL;
        end else begin
          addr = pv_q + 32'd16;
          we   = 1'b1;
          wd   = rd;
        end
      end
      ffha_pkg::S_CO_3: begin
        addr = nt_q + 32'd12;
        we   = 1'b1;
        wd   = pv_q;
      end
      ffha_pkg::S_FF_START: addr = head_q;
      ffha_pkg::S_FF_1:     addr = b_q + 32'd4;
      ffha_pkg::S_FF_2:     addr = b_q + 32'd16;
      ffha_pkg::S_FF_3:     addr = rd;
      ffha_pkg::S_SP_0: begin
        addr = b_q + ffha_pkg::HDR + s_q;
        we   = flags_o.split_ok;
        wd   = ffha_pkg::SIG_FREE;
      end
      ffha_pkg::S_SP_1: addr = b_q + 32'd8;
      ffha_pkg::S_SP_2: begin
        addr = n_q + 32'd8;
        we   = 1'b1;
        wd   = rd;
      end
      ffha_pkg::S_SP_3: begin
        addr = n_q + 32'd4;
        we   = 1'b1;
        wd   = t_q - s_q - ffha_pkg::HDR;
      end
      ffha_pkg::S_SP_5: begin
        addr = b_q + 32'd8;
        we   = 1'b1;
        wd   = n_q;
      end
      ffha_pkg::S_SP_6: begin
        addr = b_q + 32'd4;
        we   = 1'b1;
        wd   = s_q;
      end
      ffha_pkg::S_AL_1: begin
        addr = h_q;
        we   = 1'b1;
        wd   = ffha_pkg::SIG_USED;
      end
      ffha_pkg::S_AL_2: addr = h_q + 32'd4;
      ffha_pkg::S_AL_3: begin
        addr = h_q + 32'd8 + rd;
        we   = 1'b1;
        wd   = ffha_pkg::SIG_END;
      end
      ffha_pkg::S_CP_START: addr = 32'd0;
      ffha_pkg::S_CP_1:     addr = b_q + 32'd8;
      ffha_pkg::S_CP_M:     addr = b_q + 32'd4;
      ffha_pkg::S_CP_M2:    addr = b_q + 32'd8;
      ffha_pkg::S_CP_NX:    addr = stay_q ? b_q : rd;
      default: ;
    endcase
  end

  always_comb begin
    case (sweep_q)
      ffha_pkg::AW'(0): clr_val = ffha_pkg::SIG_FREE;
      ffha_pkg::AW'(1): clr_val = 32'(ffha_pkg::HEAP_BYTES) - ffha_pkg::HDR;
      ffha_pkg::AW'(2), ffha_pkg::AW'(3), ffha_pkg::AW'(4): clr_val = ffha_pkg::NIL;
      default: clr_val = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ffha_pkg::S_CLEAR) begin
      mem[sweep_q] <= clr_val;
    end else if (we && inr) begin
      mem[addr[ffha_pkg::AW+1:2]] <= wd;
    end
    mem_q <= mem[addr[ffha_pkg::AW+1:2]];
    inr_q <= inr;
  end

  always_comb begin
    flags_o.act        = act_q;
    flags_o.rd_free    = (rd == ffha_pkg::SIG_FREE);
    flags_o.rd_used    = (rd == ffha_pkg::SIG_USED);
    flags_o.rd_end     = (rd == ffha_pkg::SIG_END);
    flags_o.rd_nil     = (rd == ffha_pkg::NIL);
    flags_o.pv_nil     = (pv_q == ffha_pkg::NIL);
    flags_o.hv         = hv_q;
    flags_o.fit        = (rd >= s_q);
    flags_o.split_ok   = ((t_q - s_q) >= (ffha_pkg::HDR + ffha_pkg::MIN_ALLOC));
    flags_o.cnt_ff_ok  = (cnt_q < ffha_pkg::CNT_W'(ffha_pkg::WALK_LIMIT - 1));
    flags_o.cnt_cp_ok  = (cnt_q < ffha_pkg::CNT_W'(2 * ffha_pkg::WALK_LIMIT - 1));
    flags_o.mx_ge_s    = (mx_q >= s_q);
    flags_o.off_bad    = (off_q < 16'd12) || (off_q[1:0] != 2'b00) ||
                         (off32 >= 32'(ffha_pkg::HEAP_BYTES));
    flags_o.word_oor   = (off32 >= 32'(ffha_pkg::HEAP_WORDS));
    flags_o.sweep_last = &sweep_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= 32'd0;
      hv_q     <= 1'b1;
      ubytes_q <= 17'd0;
      ublk_q   <= 13'd0;
      fblk_q   <= 13'd1;
      sweep_q  <= '0;
    end else begin
      case (cmd_i.op)
        ffha_pkg::S_CLEAR: sweep_q <= sweep_q + 1'b1;
        ffha_pkg::S_FR_END: begin
          if (flags_o.rd_end) begin
            ubytes_q <= ubytes_q - t_q[16:0];
            ublk_q   <= ublk_q - 13'd1;
          end
        end
        ffha_pkg::S_CI_1: begin
          if (!hv_q) begin
            head_q <= n_q;
            hv_q   <= 1'b1;
            fblk_q <= fblk_q + 13'd1;
          end
        end
        ffha_pkg::S_CI_2: begin
          head_q <= n_q;
          hv_q   <= 1'b1;
          fblk_q <= fblk_q + 13'd1;
        end
        ffha_pkg::S_CO_2: begin
          if (flags_o.pv_nil && flags_o.rd_nil) begin
            hv_q   <= 1'b0;
            fblk_q <= fblk_q - 13'd1;
          end else if (flags_o.pv_nil) begin
            head_q <= rd;
            hv_q   <= 1'b1;
            fblk_q <= fblk_q - 13'd1;
          end else if (flags_o.rd_nil) begin
            fblk_q <= fblk_q - 13'd1;
          end
        end
        ffha_pkg::S_CO_3: fblk_q <= fblk_q - 13'd1;
        ffha_pkg::S_AL_3: begin
          ubytes_q <= ubytes_q + rd[16:0];
          ublk_q   <= ublk_q + 13'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ffha_pkg::S_IDLE: begin
        if (cmd_i.latch) begin
          act_q  <= action_i;
          req_q  <= request_bytes_i;
          off_q  <= byte_offset_i;
          wdat_q <= write_word_i;
        end
      end
      ffha_pkg::S_DECODE: begin
        payload_q <= 16'd0;
        rword_q   <= 32'd0;
        s_q       <= s_new;
        h_q       <= off32 - ffha_pkg::HDR;
        corrupt_q <= 1'b0;
        if (((act_q == ffha_pkg::ACT_FREE) && flags_o.off_bad) ||
            (((act_q == ffha_pkg::ACT_READ) || (act_q == ffha_pkg::ACT_WRITE)) &&
             flags_o.word_oor)) begin
          status_q <= ffha_pkg::ST_RANGE;
        end else begin
          status_q <= ffha_pkg::ST_OK;
        end
      end
      ffha_pkg::S_RW_CAP: rword_q <= rd;
      ffha_pkg::S_FR_SZ:  t_q <= rd;
      ffha_pkg::S_FR_SIG: begin
        if (!flags_o.rd_used) begin
          status_q <= ffha_pkg::ST_BADSIG;
        end
      end
      ffha_pkg::S_FR_END: begin
        if (!flags_o.rd_end) begin
          status_q <= ffha_pkg::ST_BADEND;
        end else begin
          n_q   <= h_q;
          b_q   <= h_q;
          cnt_q <= '0;
        end
      end
      ffha_pkg::S_FR_LOOP: cnt_q <= cnt_q + 1'b1;
      ffha_pkg::S_MN_0: stay_q <= 1'b0;
      ffha_pkg::S_MN_1: nx_q <= rd;
      ffha_pkg::S_MN_2: n_q <= nx_q;
      ffha_pkg::S_MN_4: t_q <= rd;
      ffha_pkg::S_MN_7: stay_q <= 1'b1;
      ffha_pkg::S_CO_1: pv_q <= rd;
      ffha_pkg::S_CO_2: nt_q <= rd;
      ffha_pkg::S_FF_START: begin
        b_q   <= head_q;
        cnt_q <= '0;
      end
      ffha_pkg::S_FF_1: begin
        if (!flags_o.rd_free) begin
          corrupt_q <= 1'b1;
        end
      end
      ffha_pkg::S_FF_2: t_q <= rd;
      ffha_pkg::S_FF_3: begin
        b_q   <= rd;
        cnt_q <= cnt_q + 1'b1;
        if (!flags_o.rd_nil && !flags_o.cnt_ff_ok) begin
          corrupt_q <= 1'b1;
        end
      end
      ffha_pkg::S_SP_0: n_q <= b_q + ffha_pkg::HDR + s_q;
      ffha_pkg::S_AL_0: begin
        n_q <= b_q;
        h_q <= b_q;
      end
      ffha_pkg::S_AL_3: payload_q <= h_q[15:0] + 16'd12;
      ffha_pkg::S_AL_NF: status_q <= corrupt_q ? ffha_pkg::ST_CORRUPT : ffha_pkg::ST_NOSPACE;
      ffha_pkg::S_CP_START: begin
        b_q   <= 32'd0;
        mx_q  <= 32'd0;
        cnt_q <= '0;
      end
      ffha_pkg::S_CP_1: stay_q <= 1'b0;
      ffha_pkg::S_CP_M2: begin
        if (rd > mx_q) begin
          mx_q <= rd;
        end
      end
      ffha_pkg::S_CP_NX: begin
        if (!stay_q) begin
          b_q <= rd;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      ffha_pkg::S_CP_FAIL: begin
        status_q  <= ffha_pkg::ST_CORRUPT;
        corrupt_q <= 1'b1;
      end
      ffha_pkg::S_FIN: begin
        status_o           <= status_q;
        payload_offset_o   <= payload_q;
        read_word_o        <= rword_q;
        bytes_in_use_o     <= ubytes_q;
        used_block_count_o <= ublk_q;
        free_block_count_o <= fblk_q;
      end
      default: ;
    endcase
  end

endmodule

>>> src/ffha_ctrl.sv
// Controller of the heap allocator: sequences chain walks, splits, merges and compaction.
module ffha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output logic             done_o,
  input  ffha_pkg::flags_t flags_i,
  output ffha_pkg::cmd_t   cmd_o
);

  logic [5:0] state_q, state_d;
  logic       ci_ret_q, ci_ret_d;   // 1: split
  logic       co_ret_q, co_ret_d;   // 1: alloc
  logic       mn_ret_q, mn_ret_d;   // 1: compact
  logic       cp_ret_q, cp_ret_d;   // 1: alloc
  logic       ff_pass_q, ff_pass_d;
  logic       done_q;

  assign busy_o    = (state_q != ffha_pkg::S_IDLE);
  assign done_o    = done_q;
  assign cmd_o.op  = state_q;
  assign cmd_o.latch = (state_q == ffha_pkg::S_IDLE) && start_i;

  always_comb begin
    state_d   = state_q;
    ci_ret_d  = ci_ret_q;
    co_ret_d  = co_ret_q;
    mn_ret_d  = mn_ret_q;
    cp_ret_d  = cp_ret_q;
    ff_pass_d = ff_pass_q;
    case (state_q)
      ffha_pkg::S_CLEAR: if (flags_i.sweep_last) state_d = ffha_pkg::S_IDLE;
      ffha_pkg::S_IDLE:  if (start_i) state_d = ffha_pkg::S_DECODE;
      ffha_pkg::S_DECODE: begin
        case (flags_i.act)
          ffha_pkg::ACT_ALLOC: begin
            ff_pass_d = 1'b0;
            state_d   = ffha_pkg::S_FF_START;
          end
          ffha_pkg::ACT_FREE: state_d = flags_i.off_bad ? ffha_pkg::S_FIN : ffha_pkg::S_FR_SZ;
          ffha_pkg::ACT_COMPACT: begin
            cp_ret_d = 1'b0;
            state_d  = ffha_pkg::S_CP_START;
          end
          ffha_pkg::ACT_READ: state_d = flags_i.word_oor ? ffha_pkg::S_FIN : ffha_pkg::S_RW_CAP;
          default: state_d = ffha_pkg::S_FIN;
        endcase
      end
      ffha_pkg::S_RW_CAP: state_d = ffha_pkg::S_FIN;
      ffha_pkg::S_FIN:    state_d = ffha_pkg::S_IDLE;
      ffha_pkg::S_FR_SZ:  state_d = ffha_pkg::S_FR_SIG;
      ffha_pkg::S_FR_SIG: state_d = flags_i.rd_used ? ffha_pkg::S_FR_END : ffha_pkg::S_FIN;
      ffha_pkg::S_FR_END: begin
        ci_ret_d = 1'b0;
        state_d  = flags_i.rd_end ? ffha_pkg::S_CI_0 : ffha_pkg::S_FIN;
      end
      ffha_pkg::S_FR_LOOP: state_d = flags_i.cnt_ff_ok ? ffha_pkg::S_MN_0 : ffha_pkg::S_FIN;
      ffha_pkg::S_CI_0: state_d = ffha_pkg::S_CI_1;
      ffha_pkg::S_CI_1, ffha_pkg::S_CI_2: begin
        if ((state_q == ffha_pkg::S_CI_1) && flags_i.hv) begin
          state_d = ffha_pkg::S_CI_2;
        end else if (ci_ret_q) begin
          state_d = ffha_pkg::S_SP_5;
        end else begin
          mn_ret_d = 1'b0;
          state_d  = ffha_pkg::S_MN_0;
        end
      end
      ffha_pkg::S_MN_0: state_d = ffha_pkg::S_MN_1;
      ffha_pkg::S_MN_1: begin
        if (!flags_i.rd_nil) begin
          state_d = ffha_pkg::S_MN_2;
        end else begin
          state_d = mn_ret_q ? ffha_pkg::S_CP_M : ffha_pkg::S_FIN;
        end
      end
      ffha_pkg::S_MN_2: begin
        if (flags_i.rd_free) begin
          co_ret_d = 1'b0;
          state_d  = ffha_pkg::S_CO_0;
        end else begin
          state_d = mn_ret_q ? ffha_pkg::S_CP_M : ffha_pkg::S_FIN;
        end
      end
      ffha_pkg::S_MN_3: state_d = ffha_pkg::S_MN_4;
      ffha_pkg::S_MN_4: state_d = ffha_pkg::S_MN_5;
      ffha_pkg::S_MN_5: state_d = ffha_pkg::S_MN_6;
      ffha_pkg::S_MN_6: state_d = ffha_pkg::S_MN_7;
      ffha_pkg::S_MN_7: state_d = mn_ret_q ? ffha_pkg::S_CP_M : ffha_pkg::S_FR_LOOP;
      ffha_pkg::S_CO_0: state_d = ffha_pkg::S_CO_1;
      ffha_pkg::S_CO_1: state_d = ffha_pkg::S_CO_2;
      ffha_pkg::S_CO_2, ffha_pkg::S_CO_3: begin
        if ((state_q == ffha_pkg::S_CO_2) && !flags_i.pv_nil && !flags_i.rd_nil) begin
          state_d = ffha_pkg::S_CO_3;
        end else begin
          state_d = co_ret_q ? ffha_pkg::S_AL_1 : ffha_pkg::S_MN_3;
        end
      end
      ffha_pkg::S_FF_START, ffha_pkg::S_FF_1, ffha_pkg::S_FF_3: begin
        if ((state_q == ffha_pkg::S_FF_START) && flags_i.hv) begin
          state_d = ffha_pkg::S_FF_1;
        end else if ((state_q == ffha_pkg::S_FF_1) && flags_i.rd_free) begin
          state_d = ffha_pkg::S_FF_2;
        end else if ((state_q == ffha_pkg::S_FF_3) && !flags_i.rd_nil &&
                     flags_i.cnt_ff_ok) begin
          state_d = ffha_pkg::S_FF_1;
        end else if (ff_pass_q) begin
          state_d = ffha_pkg::S_AL_NF;
        end else begin
          cp_ret_d = 1'b1;
          state_d  = ffha_pkg::S_CP_START;
        end
      end
      ffha_pkg::S_FF_2: state_d = flags_i.fit ? ffha_pkg::S_SP_0 : ffha_pkg::S_FF_3;
      ffha_pkg::S_SP_0: state_d = flags_i.split_ok ? ffha_pkg::S_SP_1 : ffha_pkg::S_AL_0;
      ffha_pkg::S_SP_1: state_d = ffha_pkg::S_SP_2;
      ffha_pkg::S_SP_2: state_d = ffha_pkg::S_SP_3;
      ffha_pkg::S_SP_3: begin
        ci_ret_d = 1'b1;
        state_d  = ffha_pkg::S_CI_0;
      end
      ffha_pkg::S_SP_5: state_d = ffha_pkg::S_SP_6;
      ffha_pkg::S_SP_6: state_d = ffha_pkg::S_AL_0;
      ffha_pkg::S_AL_0: begin
        co_ret_d = 1'b1;
        state_d  = ffha_pkg::S_CO_0;
      end
      ffha_pkg::S_AL_1:  state_d = ffha_pkg::S_AL_2;
      ffha_pkg::S_AL_2:  state_d = ffha_pkg::S_AL_3;
      ffha_pkg::S_AL_3:  state_d = ffha_pkg::S_FIN;
      ffha_pkg::S_AL_NF: state_d = ffha_pkg::S_FIN;
      ffha_pkg::S_CP_START: state_d = ffha_pkg::S_CP_1;
      ffha_pkg::S_CP_1: begin
        if (flags_i.rd_free) begin
          mn_ret_d = 1'b1;
          state_d  = ffha_pkg::S_MN_0;
        end else if (flags_i.rd_used) begin
          state_d = ffha_pkg::S_CP_NX;
        end else begin
          state_d = ffha_pkg::S_CP_FAIL;
        end
      end
      ffha_pkg::S_CP_M:  state_d = ffha_pkg::S_CP_M2;
      ffha_pkg::S_CP_M2: state_d = ffha_pkg::S_CP_NX;
      ffha_pkg::S_CP_NX: begin
        if (flags_i.rd_nil) begin
          if (!cp_ret_q) begin
            state_d = ffha_pkg::S_FIN;
          end else if (flags_i.mx_ge_s) begin
            ff_pass_d = 1'b1;
            state_d   = ffha_pkg::S_FF_START;
          end else begin
            state_d = ffha_pkg::S_AL_NF;
          end
        end else begin
          state_d = flags_i.cnt_cp_ok ? ffha_pkg::S_CP_1 : ffha_pkg::S_CP_FAIL;
        end
      end
      ffha_pkg::S_CP_FAIL: state_d = cp_ret_q ? ffha_pkg::S_AL_NF : ffha_pkg::S_FIN;
      default: state_d = ffha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ffha_pkg::S_CLEAR;
      ci_ret_q  <= 1'b0;
      co_ret_q  <= 1'b0;
      mn_ret_q  <= 1'b0;
      cp_ret_q  <= 1'b0;
      ff_pass_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      ci_ret_q  <= ci_ret_d;
      co_ret_q  <= co_ret_d;
      mn_ret_q  <= mn_ret_d;
      cp_ret_q  <= cp_ret_d;
      ff_pass_q <= ff_pass_d;
      done_q    <= (state_q == ffha_pkg::S_FIN);
    end
  end

endmodule

>>> src/ffha_checker.sv
// Port-level checker of the heap allocator and its bind to the top level.
module ffha_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [2:0] status_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted but not busy");

  a_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !done_o) else $error("result without request");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ffha_pkg::ST_CORRUPT)) else $error("bad status code");

endmodule

bind first_fit_heap_allocator ffha_props u_ffha_props (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .status_o (status_o)
);

>>> tb/ffha_checker.sv
// Checker for the first-fit heap allocator: predicts each result and compares it.
module ffha_checker
  import ffha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        done_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] byte_offset_i,
  input  logic [31:0] write_word_i,
  input  logic [2:0]  status_o,
  input  logic [15:0] payload_offset_o,
  input  logic [31:0] read_word_o,
  input  logic [16:0] bytes_in_use_o,
  input  logic [12:0] used_block_count_o,
  input  logic [12:0] free_block_count_o,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload;
    logic [31:0] rword;
    logic [16:0] in_use;
    logic [12:0] used_n;
    logic [12:0] free_n;
  } heap_result_t;

  logic [31:0] heap_m [0:HEAP_WORDS-1];
  logic [31:0] chain_head;
  logic        head_ok;
  logic [16:0] in_use_bytes;
  logic [12:0] used_n;
  logic [12:0] free_n;
  heap_result_t expected_q[$];

  function automatic logic [31:0] rd_w(logic [31:0] b);
    logic [31:0] i;
    i = b >> 2;
    if (i < HEAP_WORDS) return heap_m[i];
    return 32'd0;
  endfunction

  function automatic void wr_w(logic [31:0] b, logic [31:0] v);
    logic [31:0] i;
    i = b >> 2;
    if (i < HEAP_WORDS) heap_m[i] = v;
  endfunction

  function automatic void unlink(logic [31:0] h);
    logic [31:0] pv, nx;
    pv = rd_w(h + 12);
    nx = rd_w(h + 16);
    if (pv == NIL && nx == NIL) head_ok = 1'b0;
    else if (pv == NIL) begin
      wr_w(nx + 12, NIL);
      chain_head = nx;
      head_ok = 1'b1;
    end else if (nx == NIL) wr_w(pv + 16, NIL);
    else begin
      wr_w(pv + 16, nx);
      wr_w(nx + 12, pv);
    end
    free_n = free_n - 1'b1;
  endfunction

  function automatic void link_in(logic [31:0] h);
    wr_w(h + 12, NIL);
    if (!head_ok) wr_w(h + 16, NIL);
    else begin
      wr_w(h + 16, chain_head);
      wr_w(chain_head + 12, h);
    end
    chain_head = h;
    head_ok = 1'b1;
    free_n = free_n + 1'b1;
  endfunction

  function automatic void split_blk(logic [31:0] b, logic [31:0] s);
    logic [31:0] sz, n;
    sz = rd_w(b + 4);
    if (sz - s >= HDR + MIN_ALLOC) begin
      n = b + HDR + s;
      wr_w(n, SIG_FREE);
      wr_w(n + 8, rd_w(b + 8));
      wr_w(n + 4, sz - s - HDR);
      link_in(n);
      wr_w(b + 8, n);
      wr_w(b + 4, s);
    end
  endfunction

  function automatic logic [31:0] first_fit(logic [31:0] s, inout logic bad);
    logic [31:0] b;
    if (!head_ok) return NIL;
    b = chain_head;
    for (int n = 0; n < WALK_LIMIT; n++) begin
      if (rd_w(b) != SIG_FREE) begin
        bad = 1'b1;
        return NIL;
      end
      if (rd_w(b + 4) >= s) begin
        split_blk(b, s);
        return b;
      end
      b = rd_w(b + 16);
      if (b == NIL) return NIL;
    end
    bad = 1'b1;
    return NIL;
  endfunction

  function automatic logic absorb_next(logic [31:0] b);
    logic [31:0] nx;
    nx = rd_w(b + 8);
    if (nx != NIL && rd_w(nx) == SIG_FREE) begin
      unlink(nx);
      wr_w(b + 4, rd_w(b + 4) + HDR + rd_w(nx + 4));
      wr_w(b + 8, rd_w(nx + 8));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] coalesce(output logic [31:0] largest);
    logic [31:0] b, sig, nx;
    logic stay;
    b = 0;
    largest = 0;
    for (int n = 0; n < 2 * WALK_LIMIT; n++) begin
      stay = 1'b0;
      sig = rd_w(b);
      if (sig == SIG_FREE) begin
        stay = absorb_next(b);
        if (rd_w(b + 4) > largest) largest = rd_w(b + 4);
      end else if (sig != SIG_USED) begin
        largest = 0;
        return ST_CORRUPT;
      end
      nx = rd_w(b + 8);
      if (nx == NIL) return ST_OK;
      if (!stay) b = nx;
    end
    largest = 0;
    return ST_CORRUPT;
  endfunction

  function automatic void heap_reset();
    foreach (heap_m[i]) heap_m[i] = 32'd0;
    heap_m[0] = SIG_FREE;
    heap_m[1] = HEAP_BYTES - HDR;
    heap_m[2] = NIL;
    heap_m[3] = NIL;
    heap_m[4] = NIL;
    chain_head = 0;
    head_ok = 1'b1;
    in_use_bytes = '0;
    used_n = '0;
    free_n = 13'd1;
  endfunction

  function automatic heap_result_t heap_op(logic [2:0] act, logic [15:0] req,
                                           logic [15:0] off, logic [31:0] data);
    heap_result_t r;
    logic [31:0] s, h, mx, sz, o;
    logic bad;
    r = '0;
    o = {16'd0, off};
    bad = 1'b0;
    case (act)
      ACT_ALLOC: begin
        s = ({16'd0, req} + 32'd4 + ALIGN_MASK) & ~ALIGN_MASK;
        if (s < MIN_ALLOC) s = MIN_ALLOC;
        h = first_fit(s, bad);
        if (h == NIL) begin
          if (coalesce(mx) != ST_OK) bad = 1'b1;
          else if (mx >= s) h = first_fit(s, bad);
        end
        if (h == NIL) r.status = bad ? ST_CORRUPT : ST_NOSPACE;
        else begin
          unlink(h);
          wr_w(h, SIG_USED);
          sz = rd_w(h + 4);
          wr_w(h + HDR + sz - 4, SIG_END);
          in_use_bytes = in_use_bytes + sz[16:0];
          used_n = used_n + 1'b1;
          r.payload = 16'(h + HDR);
        end
      end
      ACT_FREE: begin
        if (o < HDR || (o & ALIGN_MASK) != 0 || o >= HEAP_BYTES) r.status = ST_RANGE;
        else begin
          h = o - HDR;
          sz = rd_w(h + 4);
          if (rd_w(h) != SIG_USED) r.status = ST_BADSIG;
          else if (rd_w(o + sz - 4) != SIG_END) r.status = ST_BADEND;
          else begin
            wr_w(h, SIG_FREE);
            link_in(h);
            in_use_bytes = in_use_bytes - sz[16:0];
            used_n = used_n - 1'b1;
            for (int n = 0; n < WALK_LIMIT; n++) if (!absorb_next(h)) break;
          end
        end
      end
      ACT_COMPACT: r.status = coalesce(mx);
      ACT_WRITE, ACT_READ: begin
        if (o >= HEAP_WORDS) r.status = ST_RANGE;
        else if (act == ACT_WRITE) heap_m[o] = data;
        else r.rword = heap_m[o];
      end
      default: ;
    endcase
    r.in_use = in_use_bytes;
    r.used_n = used_n;
    r.free_n = free_n;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t e, a;
    if (!rst_ni) begin
      heap_reset();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (done_o) begin
        a = '{status_o, payload_offset_o, read_word_o, bytes_in_use_o,
              used_block_count_o, free_block_count_o};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("result with no request outstanding: %p", a);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (a !== e) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", e, a);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_q.push_back(heap_op(action_i, request_bytes_i, byte_offset_i, write_word_i));
    end
  end

  assign pending_count = expected_q.size();

endmodule

>>> tb/first_fit_heap_allocator_tb.sv
// Testbench top for the first-fit heap allocator: stimulus, reset and verdict.
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        done_o;
  logic [2:0]  action_i;
  logic [15:0] request_bytes_i;
  logic [15:0] byte_offset_i;
  logic [31:0] write_word_i;
  logic [2:0]  status_o;
  logic [15:0] payload_offset_o;
  logic [31:0] read_word_o;
  logic [16:0] bytes_in_use_o;
  logic [12:0] used_block_count_o;
  logic [12:0] free_block_count_o;
  int          fail_count;
  int          pending_count;

  logic [2:0]  sent_act_q[$];
  logic [15:0] sent_req_q[$];
  logic [15:0] live_off_q[$];
  logic [15:0] live_req_q[$];
  int          n_sent;
  int          n_done;

  first_fit_heap_allocator u_top (.*);

  ffha_checker u_chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (4000) #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // track live blocks from the results of allocs
  always @(posedge clk_i) begin
    logic [2:0]  a;
    logic [15:0] r;
    if (done_o && sent_act_q.size() > 0) begin
      a = sent_act_q.pop_front();
      r = sent_req_q.pop_front();
      n_done <= n_done + 1;
      if (a == ACT_ALLOC && status_o == ST_OK) begin
        live_off_q.push_back(payload_offset_o);
        live_req_q.push_back(r);
      end
    end
  end

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 40);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send(logic [2:0] act, logic [15:0] req, logic [15:0] off, logic [31:0] data);
    idle_gap();
    start <= 1'b1;
    action_i <= act;
    request_bytes_i <= req;
    byte_offset_i <= off;
    write_word_i <= data;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    sent_act_q.push_back(act);
    sent_req_q.push_back(req);
    n_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (n_done != n_sent) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic free_live(int k);
    logic [15:0] o;
    o = live_off_q[k];
    live_off_q.delete(k);
    live_req_q.delete(k);
    send(ACT_FREE, 16'd0, o, $urandom);
  endtask

  task automatic write_live(logic [2:0] act);
    int k;
    logic [15:0] w;
    k = $urandom_range(0, live_off_q.size() - 1);
    w = (live_off_q[k] >> 2) + $urandom_range(0, (live_req_q[k] + 7) / 4);
    send(act, $urandom, w, $urandom);
  endtask

  initial begin
    int pick;
    logic [15:0] o;
    start = 1'b0;
    action_i = ACT_READ;
    request_bytes_i = '0;
    byte_offset_i = '0;
    write_word_i = '0;
    n_sent = 0;
    n_done = 0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed requests
    send(ACT_ALLOC, 16'd0, 16'd0, 32'd0);
    send(ACT_ALLOC, 16'd1, 16'hFFFF, 32'hFFFF_FFFF);
    send(ACT_ALLOC, 16'd5, 16'd0, 32'd0);
    send(ACT_ALLOC, 16'hFFFF, 16'd0, 32'd0);
    send(ACT_FREE, 16'd0, 16'd8, 32'd0);
    send(ACT_FREE, 16'd0, 16'd14, 32'd0);
    send(ACT_FREE, 16'd0, 16'hFFFC, 32'd0);
    send(ACT_FREE, 16'd0, 16'hFFFF, 32'd0);
    send(ACT_WRITE, 16'hFFFF, 16'd16383, 32'hFFFF_FFFF);
    send(ACT_READ, 16'd0, 16'd16383, 32'd0);
    send(ACT_WRITE, 16'd0, 16'd16384, 32'hA5A5_5A5A);
    send(ACT_READ, 16'd0, 16'hFFFF, 32'd0);
    send(ACT_COMPACT, 16'd0, 16'd0, 32'd0);
    send(3'd5, 16'd0, 16'd0, 32'd0);
    send(3'd6, 16'd0, 16'd0, 32'd0);
    send(3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    settle();
    free_live(0);
    send(ACT_FREE, 16'd0, 16'd12, 32'd0);
    settle();
    o = live_off_q[0];
    // break the end marker of a live block
    send(ACT_WRITE, 16'd0, (o >> 2) + 16'd1, 32'd0);
    send(ACT_FREE, 16'd0, o, 32'd0);
    send(ACT_ALLOC, 16'd65000, 16'd0, 32'd0);
    send(ACT_COMPACT, 16'd0, 16'd0, 32'd0);
    settle();

    repeat (1330) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 19) == 0) send(ACT_ALLOC, $urandom, $urandom, $urandom);
        else send(ACT_ALLOC, $urandom_range(0, 300), $urandom, $urandom);
      end else if (pick < 65) begin
        settle();
        if (live_off_q.size() > 0 && $urandom_range(0, 9) != 0)
          free_live($urandom_range(0, live_off_q.size() - 1));
        else send(ACT_FREE, $urandom, $urandom, $urandom);
      end else if (pick < 90) begin
        settle();
        if (live_off_q.size() > 0 && $urandom_range(0, 7) != 0)
          write_live((pick < 78) ? ACT_WRITE : ACT_READ);
        else if (pick < 78) send(ACT_WRITE, $urandom, $urandom_range(16384, 65535), $urandom);
        else send(ACT_READ, $urandom, $urandom, $urandom);
      end else if (pick < 96) send(ACT_COMPACT, $urandom, $urandom, $urandom);
      else send($urandom_range(5, 7), $urandom, $urandom, $urandom);
      if (live_off_q.size() > 60) begin
        settle();
        repeat (20) free_live($urandom_range(0, live_off_q.size() - 1));
      end
    end

    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
